// ===== rtl/core/tdk_pkg.sv =====
// ---------------------------------------------------------------------------
// tdk_pkg
// Shared types and constants for the packed key table with delete-by-key.
// ---------------------------------------------------------------------------
package tdk_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // item kinds; the fourth code is unused and is treated as a no-op
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SHIFT,
        S_RD_REQ,
        S_RD_WAIT,
        S_FINISH
    } tdk_state_t;

    // result/update operation applied by the datapath
    typedef enum logic [3:0] {
        OP_NONE,
        OP_APPEND,
        OP_FULL,
        OP_HIT,
        OP_MISS,
        OP_DEL_DONE,
        OP_RD_OK,
        OP_RD_BAD,
        OP_IGNORE
    } tdk_op_t;

    typedef struct packed {
        logic    load;      // latch input item, rewind scan index
        logic    issue;     // read entry at scan index, advance index
        logic    rd_slot;   // read entry at requested slot
        logic    shift_wr;  // write last read entry one place down
        tdk_op_t op;
        logic    out_load;  // move result into output register
    } tdk_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       idx_lt_cnt;
        logic       pend;
        logic       hit;
        logic       slot_ok;
        logic       out_free;
    } tdk_stat_t;

endpackage

// ===== rtl/core/tdk_req_if.sv =====
// ---------------------------------------------------------------------------
// tdk_req_if
// Request channel: item kind, value or key, and read slot.
// ---------------------------------------------------------------------------
interface tdk_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] key_value;
    logic [7:0]         slot;

    modport source (output valid, output kind, output key_value, output slot, input ready);
    modport sink   (input valid, input kind, input key_value, input slot, output ready);
endinterface

// ===== rtl/core/tdk_rsp_if.sv =====
// ---------------------------------------------------------------------------
// tdk_rsp_if
// Response channel: status, position, occupancy and read data.
// ---------------------------------------------------------------------------
interface tdk_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         position;
    logic [8:0]         occupancy;
    logic signed [31:0] read_data;

    modport source (output valid, output status, output position, output occupancy,
                    output read_data, input ready);
    modport sink   (input valid, input status, input position, input occupancy,
                    input read_data, output ready);
endinterface

// ===== rtl/core/tdk_ram.sv =====
// ---------------------------------------------------------------------------
// tdk_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tdk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tdk_ctrl.sv =====
// ---------------------------------------------------------------------------
// tdk_ctrl
// Sequencer: dispatches each item and steps scan, shift and read phases.
// ---------------------------------------------------------------------------
module tdk_ctrl
    import tdk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  tdk_stat_t stat,
    output tdk_cmd_t  cmd
);

    tdk_state_t state_reg;
    tdk_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.op     = OP_NONE;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                unique case (stat.kind)
                    KIND_APPEND:
                    begin
                        cmd.op     = stat.full ? OP_FULL : OP_APPEND;
                        state_next = S_FINISH;
                    end
                    KIND_DELETE:
                    begin
                        state_next = S_SCAN;
                    end
                    KIND_READ:
                    begin
                        state_next = S_RD_REQ;
                    end
                    default:
                    begin
                        cmd.op     = OP_IGNORE;
                        state_next = S_FINISH;
                    end
                endcase
            end

            // reads are pipelined: compare the word fetched last cycle
            S_SCAN:
            begin
                cmd.issue = stat.idx_lt_cnt;
                if (stat.pend && stat.hit)
                begin
                    cmd.op     = OP_HIT;
                    state_next = S_SHIFT;
                end
                else if (!stat.pend && !stat.idx_lt_cnt)
                begin
                    cmd.op     = OP_MISS;
                    state_next = S_FINISH;
                end
            end

            S_SHIFT:
            begin
                cmd.issue    = stat.idx_lt_cnt;
                cmd.shift_wr = stat.pend;
                if (!stat.pend && !stat.idx_lt_cnt)
                begin
                    cmd.op     = OP_DEL_DONE;
                    state_next = S_FINISH;
                end
            end

            S_RD_REQ:
            begin
                if (stat.slot_ok)
                begin
                    cmd.rd_slot = 1'b1;
                    state_next  = S_RD_WAIT;
                end
                else
                begin
                    cmd.op     = OP_RD_BAD;
                    state_next = S_FINISH;
                end
            end

            S_RD_WAIT:
            begin
                cmd.op     = OP_RD_OK;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/tdk_dpath.sv =====
// ---------------------------------------------------------------------------
// tdk_dpath
// Datapath: entry RAM, count, scan index, result and output registers.
// ---------------------------------------------------------------------------
module tdk_dpath
    import tdk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         kind,
    input  logic signed [31:0] key_value,
    input  logic [7:0]         slot,
    input  tdk_cmd_t           cmd,
    output tdk_stat_t          stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [1:0]         rsp_status,
    output logic [7:0]         rsp_position,
    output logic [8:0]         rsp_occupancy,
    output logic signed [31:0] rsp_read_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  pend_reg;
    logic [AW-1:0]         pidx_reg, pidx_next;
    logic [1:0]            kind_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [7:0]            slot_reg;

    logic [1:0]            res_status_reg, res_status_next;
    logic [AW-1:0]         res_pos_reg, res_pos_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;

    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [7:0]            out_pos_reg;
    logic [8:0]            out_occ_reg;
    logic [31:0]           out_data_reg;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    tdk_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shift writes land one below the word just read
    assign rd_en   = cmd.issue || cmd.rd_slot;
    assign rd_addr = cmd.rd_slot ? AW'(slot_reg) : idx_reg[AW-1:0];
    assign wr_en   = (cmd.op == OP_APPEND) || cmd.shift_wr;
    assign wr_addr = cmd.shift_wr ? (pidx_reg - 1'b1) : cnt_reg[AW-1:0];
    assign wr_data = cmd.shift_wr ? rd_data : key_reg;

    assign idx_next  = cmd.load ? '0 : (cmd.issue ? idx_reg + 1'b1 : idx_reg);
    assign pidx_next = cmd.issue ? idx_reg[AW-1:0] : pidx_reg;

    always_comb
    begin
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_data_next   = res_data_reg;
        unique case (cmd.op)
            OP_APPEND:
            begin
                cnt_next        = cnt_reg + 1'b1;
                res_status_next = ST_OK;
                res_pos_next    = cnt_reg[AW-1:0];
                res_data_next   = '0;
            end
            OP_FULL:
            begin
                res_status_next = ST_FULL;
                res_pos_next    = '0;
                res_data_next   = '0;
            end
            OP_HIT:
            begin
                res_status_next = ST_OK;
                res_pos_next    = pidx_reg;
                res_data_next   = '0;
            end
            OP_MISS:
            begin
                res_status_next = ST_NOT_FOUND;
                res_pos_next    = '0;
                res_data_next   = '0;
            end
            OP_DEL_DONE:
            begin
                cnt_next = cnt_reg - 1'b1;
            end
            OP_RD_OK:
            begin
                res_status_next = ST_OK;
                res_pos_next    = AW'(slot_reg);
                res_data_next   = rd_data;
            end
            OP_RD_BAD:
            begin
                res_status_next = ST_RANGE;
                res_pos_next    = '0;
                res_data_next   = '0;
            end
            OP_IGNORE:
            begin
                res_status_next = ST_OK;
                res_pos_next    = '0;
                res_data_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            pend_reg <= cmd.issue;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_data_reg   <= res_data_next;
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= DATA_WIDTH'(key_value);
            slot_reg <= slot;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= 8'(res_pos_reg);
            out_occ_reg    <= 9'(cnt_reg);
            out_data_reg   <= 32'(signed'(res_data_reg));
        end
    end

    assign stat.kind       = kind_reg;
    assign stat.full       = (cnt_reg == CW'(DEPTH));
    assign stat.idx_lt_cnt = (idx_reg < cnt_reg);
    assign stat.pend       = pend_reg;
    assign stat.hit        = (rd_data == key_reg);
    assign stat.slot_ok    = (CMPW'(slot_reg) < CMPW'(cnt_reg));
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_position  = out_pos_reg;
    assign rsp_occupancy = out_occ_reg;
    assign rsp_read_data = out_data_reg;

endmodule

// ===== rtl/core/table_delete_by_key_compact.sv =====
// ---------------------------------------------------------------------------
// table_delete_by_key_compact
// Packed table of signed words: append, delete first match with compaction,
// and indexed read.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one item (kind, key_value, slot); rsp returns exactly one
//   result per item (status, position, occupancy, read_data).
//   One item is worked on at a time; req.ready is high only while idle.
//   An append, a full table or an unused kind goes from dispatch straight to
//   the result; a read checks the slot against occupancy and, in range,
//   fetches the entry; a delete scans for the key and, on a hit, moves the
//   later entries down.
//   The single RAM read port sets the delete time: one entry is fetched per
//   cycle, first while searching, then while moving later entries down.
//   A finished result sits in an output register; if rsp is stalled the
//   next item is still accepted and worked on up to its result, which then
//   waits until the register is free.
//   Reset empties the table (count zero); entry contents are not cleared and
//   no clearing pass runs, so items are accepted right after reset.
// ---------------------------------------------------------------------------
module table_delete_by_key_compact
    import tdk_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    tdk_req_if.sink   req,
    tdk_rsp_if.source rsp
);

    tdk_cmd_t  cmd;
    tdk_stat_t stat;

    tdk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tdk_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (req.kind),
        .key_value     (req.key_value),
        .slot          (req.slot),
        .cmd           (cmd),
        .stat          (stat),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_status    (rsp.status),
        .rsp_position  (rsp.position),
        .rsp_occupancy (rsp.occupancy),
        .rsp_read_data (rsp.read_data)
    );

    // one item in flight: an accepted item closes the request side
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item accepted while another is in flight");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == 9'(DEPTH))
        else $error("table full reported below capacity");

    a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL ||
                      rsp.status == ST_RANGE) |-> rsp.position == 8'd0)
        else $error("failed item reports nonzero position");

    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.read_data == 32'sd0)
        else $error("failed item reports nonzero data");

    // no shift write may coincide with an item load, a slot read or an output transfer
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> !cmd.rd_slot && !cmd.out_load && !cmd.load)
        else $error("shift write overlaps another command");

endmodule
